/* src/brf_pkg.sv */
// shared types and constants for the byte ring fifo with message admission
package brf_pkg;

   // field widths of the stream words and registers
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 13;
   localparam int FILL_W   = 13;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int REG_W    = 13;
   localparam int REG_IDX_W = 1;

   // packed word widths; the data words are padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;

   // defaults
   localparam int DEPTH_DEF     = 4096;
   localparam int MAX_BURST_DEF = 64;
   localparam int SIZE_RST      = 4096;

   // item kinds
   localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_AUTO_CLEAR  = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_BUFFER_SIZE = 1'd1;

   typedef enum logic {
      S_IDLE,
      S_BURST
   } ctrl_state_type;

   // result description handed from the controller to the output pipeline
   typedef struct packed {
      logic                from_mem;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
   } rsp_meta_type;

endpackage

/* src/brf_ram.sv */
// generic single-write, single-read ram with registered read data
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/brf_ctrl.sv */
// pointer, fill and admission control with read burst sequencer
module brf_ctrl
   import brf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int MAX_BURST = MAX_BURST_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // item side
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [MODE_W-1:0]        mode,
   input  logic [BYTE_W-1:0]        data_in,
   input  logic                     first_of_message,
   input  logic [LEN_W-1:0]         length,
   // register writes
   input  logic                     csr_we,
   input  logic [REG_IDX_W-1:0]     csr_index,
   input  logic [REG_W-1:0]         csr_wdata,
   // ram ports
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [BYTE_W-1:0]        wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   // result stage
   input  logic                     stage_free,
   output logic                     stage_load,
   output rsp_meta_type             stage_meta
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int W  = ((CW > LEN_W) ? CW : LEN_W) + 1;
   localparam int BW = $clog2(MAX_BURST + 1);
   localparam int RST_EFF = (DEPTH < SIZE_RST) ? DEPTH : SIZE_RST;

   ctrl_state_type   state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    size_ff, size_in;
   logic             acc_ff, acc_in;
   logic             auto_ff, auto_in;
   logic [BW-1:0]    cnt_ff, cnt_in;

   logic             accept;
   logic [W-1:0]     fill_w, len_w, size_w, cfg_w;
   logic [W-1:0]     burst_min, burst_n;
   logic             burst_go;

   // write path scratch
   logic             w_acc, w_clr;
   logic [STATUS_W-1:0] w_stat;
   logic [W-1:0]     w_fill, w_pos;
   logic [AW-1:0]    w_head;
   logic [CW-1:0]    head_inc;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && stage_free;

   assign fill_w = W'(fill_ff);
   assign len_w  = W'(length);
   assign size_w = W'(size_ff);
   assign cfg_w  = W'(csr_wdata);

   assign burst_min = (len_w < fill_w) ? len_w : fill_w;
   assign burst_n   = (burst_min > W'(MAX_BURST)) ? W'(MAX_BURST) : burst_min;
   assign burst_go  = (fill_ff != '0) && (burst_n != '0);

   assign head_inc = CW'(head_ff) + CW'(1);

   // admission decision for a write byte
   always_comb begin
      w_acc  = acc_ff;
      w_clr  = 1'b0;
      w_stat = STATUS_OK;
      if (first_of_message) begin
         if (length == '0) begin
            w_acc = 1'b0;
         end else if (fill_w + len_w > size_w) begin
            if (auto_ff && (len_w <= size_w)) begin
               w_clr  = 1'b1;
               w_acc  = 1'b1;
               w_stat = STATUS_CLEARED;
            end else begin
               w_acc = 1'b0;
            end
         end else begin
            w_acc = 1'b1;
         end
      end
      w_fill = w_clr ? '0 : fill_w;
      w_head = w_clr ? '0 : head_ff;
      w_pos  = W'(w_head) + w_fill;
      if (w_pos >= size_w) begin
         w_pos = w_pos - size_w;
      end
      if (!w_acc || (w_fill >= size_w)) begin
         w_stat = STATUS_REJECT;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (mode == MODE_READ) && burst_go) begin
               state_in = S_BURST;
            end
         end
         S_BURST: begin
            if (stage_free && (cnt_ff == BW'(1))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in    = head_ff;
      fill_in    = fill_ff;
      size_in    = size_ff;
      acc_in     = acc_ff;
      auto_in    = auto_ff;
      cnt_in     = cnt_ff;
      wr_en      = 1'b0;
      wr_addr    = w_pos[AW-1:0];
      wr_data    = data_in;
      rd_en      = 1'b0;
      rd_addr    = head_ff;
      stage_load = 1'b0;
      stage_meta = '{from_mem: 1'b0, last: 1'b1, status: STATUS_OK,
                     fill: FILL_W'(fill_ff)};

      priority if (csr_we) begin
         unique case (csr_index)
            REG_AUTO_CLEAR: auto_in = csr_wdata[0];
            REG_BUFFER_SIZE: begin
               if (csr_wdata == '0) begin
                  size_in = CW'(1);
               end else if (cfg_w > W'(DEPTH)) begin
                  size_in = CW'(DEPTH);
               end else begin
                  size_in = CW'(csr_wdata);
               end
               head_in = '0;
               fill_in = '0;
               acc_in  = 1'b0;
            end
            default: ;
         endcase
      end else if (accept) begin
         stage_load = 1'b1;
         unique case (mode)
            MODE_WRITE: begin
               acc_in  = w_acc;
               head_in = w_head;
               fill_in = CW'(w_fill);
               if (w_stat != STATUS_REJECT) begin
                  wr_en   = 1'b1;
                  fill_in = CW'(w_fill) + CW'(1);
               end
               stage_meta.status = w_stat;
               stage_meta.fill   = FILL_W'(fill_in);
            end
            MODE_READ: begin
               if (fill_ff == '0) begin
                  stage_meta.status = STATUS_EMPTY;
               end else if (burst_go) begin
                  // results come from the burst cycles instead
                  stage_load = 1'b0;
                  cnt_in     = BW'(burst_n);
               end
            end
            MODE_CLEAR: begin
               head_in = '0;
               fill_in = '0;
               acc_in  = 1'b0;
               stage_meta.fill = '0;
            end
            MODE_UNUSED: ;
            default: ;
         endcase
      end else if ((state_ff == S_BURST) && stage_free) begin
         // pop one byte from the head
         rd_en      = 1'b1;
         stage_load = 1'b1;
         head_in    = (head_inc >= size_ff) ? '0 : head_inc[AW-1:0];
         fill_in    = fill_ff - CW'(1);
         cnt_in     = cnt_ff - BW'(1);
         stage_meta.from_mem = 1'b1;
         stage_meta.last     = (cnt_ff == BW'(1));
         stage_meta.fill     = FILL_W'(fill_in);
      end else begin
         // nothing moves this cycle
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         size_ff  <= CW'(RST_EFF);
         acc_ff   <= 1'b0;
         auto_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         size_ff  <= size_in;
         acc_ff   <= acc_in;
         auto_ff  <= auto_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* src/byte_ring_fifo_msg_admit.sv */
// top level of the byte ring fifo with whole-message admission
//
// usage
//   req_ stream carries one word per item: write a byte, request a read burst, or clear
//   the buffer. the first byte of a message carries its length and decides admission for
//   the whole message; an overflowing message is dropped, or with auto_clear set and a
//   message no longer than the buffer, the buffer is emptied and the message taken.
//   rsp_ stream carries one word per write, clear, other item or read that pops nothing, and
//   one word per byte popped by a read burst; rsp_tlast marks the final word caused by an item.
//   csr_ port writes auto_clear and buffer_size; writing buffer_size empties the buffer.
// timing
//   a write, clear or single-word read result passes the stage register, then the output
//   register on its way to rsp_; a read burst first enters the sequencer state, then pops
//   one byte per cycle while rsp_ does not stall. writes and clears are taken one per cycle
//   while req_tready is high. a read of n bytes (capped at fill and MAX_BURST) holds off
//   req_ until its last byte is popped, the sequencer reading the byte ram once per byte.
// reset and stall
//   reset empties the buffer, drops any open message and sets buffer_size to 4096 or DEPTH
//   if smaller; no memory sweep is run. when rsp_tready is low the output register and the
//   stage behind it hold, and req_tready drops once both are full.
module byte_ring_fifo_msg_admit
   import brf_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int MAX_BURST = MAX_BURST_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data_in[7:0], length[20:8], zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // mode[1:0], first_of_message[2]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // data_out[7:0], fill_level[20:8], zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser,  // data_valid[0], status[2:1]
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(DEPTH);

   // ram connections
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   // stage in front of the output register, lined up with the ram read data
   logic              stage_free, stage_load;
   rsp_meta_type      stage_meta;
   logic              stg_vld_ff;
   rsp_meta_type      stg_meta_ff;

   // output register
   logic              rsp_free;
   logic              rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic              rsp_last_ff;
   logic [BYTE_W-1:0] stg_byte;

   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign stage_free = !stg_vld_ff || rsp_free;

   brf_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .mode             (req_tuser[MODE_W-1:0]),
      .data_in          (req_tdata[BYTE_W-1:0]),
      .first_of_message (req_tuser[MODE_W]),
      .length           (req_tdata[BYTE_W +: LEN_W]),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .stage_free       (stage_free),
      .stage_load       (stage_load),
      .stage_meta       (stage_meta)
   );

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram data only updates on a read, so it holds while this stage stalls
   assign stg_byte = stg_meta_ff.from_mem ? rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (stage_free) begin
            stg_vld_ff <= stage_load;
         end
         if (rsp_free) begin
            rsp_vld_ff <= stg_vld_ff;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (stage_free && stage_load) begin
         stg_meta_ff <= stage_meta;
      end
      if (rsp_free && stg_vld_ff) begin
         rsp_data_ff <= RSP_DATA_W'({stg_meta_ff.fill, stg_byte});
         rsp_user_ff <= {stg_meta_ff.status, stg_meta_ff.from_mem};
         rsp_last_ff <= stg_meta_ff.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
